// ----- hdl/depth_linearizer_top_defines.svh -----
// shared assertion macros for the depth linearizer
`ifndef DEPTH_LINEARIZER_TOP_DEFINES_SVH
`define DEPTH_LINEARIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property checked out of reset
`define DL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// property checked during reset as well
`define DL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DL_ASSERT(lbl, prop, msg)
`define DL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/dlin_pkg.sv -----
package dlin_pkg;

    localparam int DEPTH_FRACTION_BITS = 24;
    localparam int RAW_W = 25;
    localparam int Q_W = 32;
    localparam int DIV_STAGES = Q_W;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CONV_PERSP     = 2'd0,
        CONV_REV_PERSP = 2'd1,
        CONV_WBUF      = 2'd2,
        CONV_REV_WBUF  = 2'd3
    } conv_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR = 2'd0,
        REG_FAR  = 2'd1,
        REG_CONV = 2'd2
    } reg_idx_t;

    // one beat inside the divider chain
    typedef struct packed {
        logic          valid;
        logic          inf;
        logic          wmode;
        logic [Q_W-1:0] wres;
        logic [Q_W-1:0] den;
        logic [Q_W-1:0] rem;
        logic [Q_W-1:0] num_lo;
        logic [Q_W-1:0] quo;
    } div_beat_t;

    // one restoring division step, one quotient bit
    function automatic div_beat_t div_step(input div_beat_t b);
        div_beat_t     r;
        logic [Q_W:0]  trial;
        logic [Q_W:0]  diff;
        r     = b;
        trial = {b.rem, b.num_lo[Q_W-1]};
        diff  = trial - {1'b0, b.den};
        if (!diff[Q_W]) begin
            r.rem = diff[Q_W-1:0];
            r.quo = {b.quo[Q_W-2:0], 1'b1};
        end else begin
            r.rem = trial[Q_W-1:0];
            r.quo = {b.quo[Q_W-2:0], 1'b0};
        end
        r.num_lo = {b.num_lo[Q_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

// ----- hdl/depth_linearizer_top.sv -----
// depth linearizer: one raw depth beat in, one linear Q16.16 depth beat out, one beat per
// clock sustained while m_ready is held high, through the 32-stage restoring divider
// (one quotient bit per stage) that serves the perspective modes, the W modes ride through it
// unchanged. near*far is held precomputed from the plane registers. An input skid beat keeps
// s_ready registered so the input side never depends on m_ready in the same cycle.
// A plane setup with near zero or far not beyond near gives all ones with is_infinite set.
`include "depth_linearizer_top_defines.svh"
module depth_linearizer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [dlin_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dlin_pkg::RAW_W-1:0]   s_raw_depth,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dlin_pkg::Q_W-1:0]     m_linear_depth,
    output logic                         m_is_infinite
);
    import dlin_pkg::*;

    localparam int CW = (RAW_W > DEPTH_FRACTION_BITS ? RAW_W : DEPTH_FRACTION_BITS + 1);
    localparam logic [CW-1:0] ONE = CW'(1) << DEPTH_FRACTION_BITS;
    localparam int PW = CW + Q_W;

    // configuration registers
    logic [Q_W-1:0]   near_reg, far_reg;
    conv_t            conv_reg;
    // values derived from the planes, registered
    logic [2*Q_W-1:0] nf_reg;
    logic [Q_W-1:0]   range_reg;
    logic             inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg <= 32'd65536;
            far_reg  <= 32'd6553600;
            conv_reg <= CONV_PERSP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NEAR: near_reg <= cfg_wdata;
                REG_FAR:  far_reg  <= cfg_wdata;
                REG_CONV: conv_reg <= conv_t'(cfg_wdata[1:0]);
                default: ;
            endcase
        end
        nf_reg    <= (2*Q_W)'(near_reg) * (2*Q_W)'(far_reg);
        range_reg <= far_reg - near_reg;
        inv_reg   <= (near_reg == '0) || (far_reg <= near_reg);
    end

    // pipeline moves when the output register is free or being drained
    logic en;
    assign en = !m_valid || m_ready;

    // input skid beat
    logic                 skid_full_reg;
    logic [RAW_W-1:0]     skid_data_reg;
    logic                 in_take;
    assign s_ready = !skid_full_reg;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (en) begin
            skid_full_reg <= 1'b0;
        end else if (in_take) begin
            skid_full_reg <= 1'b1;
        end
        if (in_take && !en) begin
            skid_data_reg <= s_raw_depth;
        end
    end

    // stage 1: clamp the sample
    logic              s1_valid_reg;
    logic [CW-1:0]     s1_c_reg;
    logic              s0_valid;
    logic [RAW_W-1:0]  s0_raw;
    logic [CW-1:0]     s0_ext;
    assign s0_valid = skid_full_reg || s_valid;
    assign s0_raw   = skid_full_reg ? skid_data_reg : s_raw_depth;
    assign s0_ext   = CW'(s0_raw);

    // stage 2: t = c * range >> fraction bits
    logic              s2_valid_reg;
    logic [Q_W-1:0]    s2_t_reg;
    logic [PW-1:0]     prod;
    assign prod = PW'(s1_c_reg) * PW'(range_reg);

    // stage 3: denominator and linear result, load the divider
    div_beat_t         div_reg [DIV_STAGES+1];
    div_beat_t         div_load;
    logic [Q_W-1:0]    add_t, sub_t;
    assign add_t = near_reg + s2_t_reg;
    assign sub_t = far_reg - s2_t_reg;

    always_comb begin
        div_load        = '0;
        div_load.valid  = s2_valid_reg;
        div_load.inf    = inv_reg;
        div_load.wmode  = (conv_reg == CONV_WBUF) || (conv_reg == CONV_REV_WBUF);
        div_load.rem    = nf_reg[2*Q_W-1:Q_W];
        div_load.num_lo = nf_reg[Q_W-1:0];
        case (conv_reg)
            CONV_PERSP:     div_load.den = sub_t;
            CONV_REV_PERSP: div_load.den = add_t;
            CONV_WBUF:      div_load.wres = add_t;
            default:        div_load.wres = sub_t;
        endcase
    end

    // output register
    logic              m_valid_reg;
    logic [Q_W-1:0]    m_data_reg;
    logic              m_inf_reg;
    div_beat_t         last;
    assign last = div_reg[DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i <= DIV_STAGES; i++) begin
                div_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            s1_valid_reg <= s0_valid;
            s2_valid_reg <= s1_valid_reg;
            div_reg[0]   <= div_load;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                div_reg[i] <= div_step(div_reg[i-1]);
            end
            m_valid_reg  <= last.valid;
        end
        if (en) begin
            s1_c_reg <= (s0_ext > ONE) ? ONE : s0_ext;
            s2_t_reg <= prod[DEPTH_FRACTION_BITS +: Q_W];
            m_inf_reg <= last.inf;
            if (last.inf) begin
                m_data_reg <= '1;
            end else if (last.wmode) begin
                m_data_reg <= last.wres;
            end else begin
                m_data_reg <= last.quo;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_linear_depth = m_data_reg;
    assign m_is_infinite  = m_inf_reg;

    `DL_ASSERT(a_inf_all_ones, m_valid && m_is_infinite |-> m_linear_depth == '1, "inf not ones")
    `DL_ASSERT(a_skid_holds, skid_full_reg && !en |=> skid_full_reg, "skid beat lost")
    `DL_ASSERT(a_skid_only_stall, !skid_full_reg && in_take && !en |=> skid_full_reg, "no skid")
    `DL_ASSERT(a_stall_holds, m_valid && !m_ready |=> $stable(div_reg[0]), "pipe moved in stall")
    `DL_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid && s_ready, "reset not clean")
endmodule

// ----- dv/tb_depth_linearizer_top.sv -----
module tb_depth_linearizer_top;
    import dlin_pkg::*;

    // expected result of one depth beat
    typedef struct packed {
        logic [Q_W-1:0] depth;
        logic           inf;
    } depth_result_t;

    // predictor holding its own copy of the plane registers
    class depth_scoreboard;
        logic [31:0]    near_q;
        logic [31:0]    far_q;
        conv_t          conv;
        depth_result_t  pending[$];
        int             errors;

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_NEAR: near_q = val;
                REG_FAR:  far_q = val;
                REG_CONV: conv = conv_t'(val[1:0]);
                default: ;
            endcase
        endfunction

        function depth_result_t linearize(logic [RAW_W-1:0] raw);
            depth_result_t r;
            logic [63:0]   n, f, c, t, q;
            n = near_q;
            f = far_q;
            c = raw;
            r.inf = 1'b0;
            if (n == 0 || f <= n) begin
                r.depth = '1;
                r.inf = 1'b1;
                return r;
            end
            if (c > (64'd1 << DEPTH_FRACTION_BITS)) c = 64'd1 << DEPTH_FRACTION_BITS;
            t = (c * (f - n)) >> DEPTH_FRACTION_BITS;
            case (conv)
                CONV_PERSP:     q = (n * f) / (f - t);
                CONV_REV_PERSP: q = (n * f) / (n + t);
                CONV_WBUF:      q = n + t;
                default:        q = f - t;
            endcase
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            r.depth = q[31:0];
            return r;
        endfunction

        function void note_input(logic [RAW_W-1:0] raw);
            pending = {pending, linearize(raw)};
        endfunction

        task check_result(logic [Q_W-1:0] depth, logic inf);
            depth_result_t e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected beat depth=%h", depth));
                return;
            end
            e = pending.pop_front();
            if (depth !== e.depth)
                report_mismatch($sformatf("linear_depth %h, want %h", depth, e.depth));
            if (inf !== e.inf)
                report_mismatch($sformatf("is_infinite %b, want %b", inf, e.inf));
        endtask

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [RAW_W-1:0]     s_raw_depth = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [Q_W-1:0]       m_linear_depth;
    logic                 m_is_infinite;

    depth_scoreboard sb = new();
    int  cycle_count = 0;
    bit  sink_hold = 1'b0;       // long receiver hold-off in progress

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;

    depth_linearizer_top DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_depth_linearizer_top: errors");
            $finish;
        end
    end

    // result checker, samples at the edge where the beat is taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_linear_depth, m_is_infinite);
    end

    // input bookkeeping on accepted beats
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_raw_depth);
    end

    // gap length: mostly short, sometimes long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, with stretches of no stalls and one long hold-off
    initial begin
        int g;
        int phase;
        phase = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                sink_hold = 1'b0;
            end
            phase++;
            g = ((phase / 200) % 3 == 1) ? 0 : pick_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_planes(logic [31:0] n, logic [31:0] f, conv_t c);
        write_reg(REG_NEAR, n);
        write_reg(REG_FAR, f);
        write_reg(REG_CONV, 32'(c));
        @(posedge aclk);
    endtask

    // one beat, valid held until taken; back-to-back beats keep valid high
    task automatic send_depth(logic [RAW_W-1:0] raw, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_depth <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [RAW_W-1:0] rand_depth();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return RAW_W'(1 << DEPTH_FRACTION_BITS);
        if (p == 1) return RAW_W'($urandom_range(0, 3));
        if (p == 2) return RAW_W'($urandom) | RAW_W'(1 << DEPTH_FRACTION_BITS);
        return RAW_W'($urandom_range(0, (1 << DEPTH_FRACTION_BITS)));
    endfunction

    function automatic logic [31:0] rand_plane();
        case ($urandom_range(0, 4))
            0: return $urandom_range(1, 16);
            1: return $urandom;
            2: return $urandom_range(32'h1000, 32'h0100_0000);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 16);
            default: return $urandom_range(32'h0001_0000, 32'h0064_0000);
        endcase
    endfunction

    initial begin
        logic [RAW_W-1:0] edge_depths[8];
        logic [31:0] n, f;
        int phase_cnt;
        edge_depths = '{25'd0, 25'd1, 25'h0FF_FFFF, 25'h100_0000, 25'h100_0001,
                        25'h1FF_FFFF, 25'h080_0000, 25'h155_5555};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        sb.near_q = 32'd65536;
        sb.far_q = 32'd6553600;
        sb.conv = CONV_PERSP;
        sb.errors = 0;
        @(posedge aclk);

        // directed: reset planes in every convention, edge depths
        for (int c = 0; c < 4; c++) begin
            write_reg(REG_CONV, 32'(c));
            foreach (edge_depths[i]) send_depth(edge_depths[i], 1'b0);
            drain();
        end
        // extreme and invalid plane setups
        set_planes(32'd1, 32'hFFFF_FFFF, CONV_PERSP);
        foreach (edge_depths[i]) send_depth(edge_depths[i], 1'b0);
        drain();
        set_planes(32'hFFFF_FFFE, 32'hFFFF_FFFF, CONV_REV_PERSP);
        send_depth(25'h100_0000, 1'b0);
        send_depth(25'h0, 1'b0);
        drain();
        set_planes(32'd0, 32'd100, CONV_WBUF);       // zero near plane
        send_depth(25'h1FF_FFFF, 1'b0);
        drain();
        set_planes(32'd500, 32'd500, CONV_REV_WBUF); // far equal to near
        send_depth(25'd7, 1'b0);
        drain();
        set_planes(32'hFFFF_FFFF, 32'd3, CONV_PERSP); // far below near
        send_depth(25'h0AB_CDEF, 1'b0);
        drain();

        // back-pressure: hold off the receiver while beats keep coming
        set_planes(32'd65536, 32'd6553600, CONV_REV_PERSP);
        sink_hold = 1'b1;
        for (int i = 0; i < 120; i++) send_depth(rand_depth(), 1'b0);
        drain();

        // random phases, each with its own plane setup
        for (phase_cnt = 0; phase_cnt < 26; phase_cnt++) begin
            n = rand_plane();
            f = rand_plane();
            if ($urandom_range(0, 5) != 0 && f <= n) begin
                logic [31:0] tmp;
                tmp = n; n = f; f = tmp;
            end
            set_planes(n, f, conv_t'($urandom_range(0, 3)));
            for (int i = 0; i < 55; i++) send_depth(rand_depth(), (phase_cnt % 4) != 2);
            drain();
        end

        if (sb.errors == 0) begin
            $display("tb_depth_linearizer_top: clean");
        end else begin
            $display("tb_depth_linearizer_top: errors");
        end
        $finish;
    end

endmodule
